FILE: sv/ata_taskfile_command_issuer_core_assert.svh
// Assertion macros for the ATA taskfile command issuer checker.
`ifndef ATA_TASKFILE_COMMAND_ISSUER_CORE_ASSERT_SVH
`define ATA_TASKFILE_COMMAND_ISSUER_CORE_ASSERT_SVH

// Same-cycle implication, clocked on clk_i, off while in reset.
`define ATCI_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("atci: same-cycle check failed");

// Next-cycle implication, clocked on clk_i, off while in reset.
`define ATCI_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("atci: next-cycle check failed");

`endif

FILE: sv/atci_pkg.sv
// Types, constants and the beat table of the ATA taskfile command issuer.
package atci_pkg;

  localparam int unsigned CmdW    = 2;
  localparam int unsigned LbaW    = 48;
  localparam int unsigned CntW    = 17;
  localparam int unsigned EndW    = 49;
  localparam int unsigned Cap28W  = 29;
  localparam int unsigned Cap48W  = 49;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 49;
  localparam int unsigned StepW   = 4;
  localparam int unsigned QDepth  = 2;
  localparam int unsigned QPtrW   = $clog2(QDepth);
  localparam int unsigned QCntW   = $clog2(QDepth + 1);

  localparam logic [CmdW-1:0] CmdRead  = 2'd0;
  localparam logic [CmdW-1:0] CmdWrite = 2'd1;
  localparam logic [CmdW-1:0] CmdFlush = 2'd2;
  localparam logic [CmdW-1:0] CmdBad   = 2'd3;

  localparam logic [CfgIdxW-1:0] CfgLba48Capable = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgIsSlave      = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgLba28Cap     = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgLba48Cap     = 2'd3;

  localparam logic [2:0] OffNone  = 3'd0;
  localparam logic [2:0] OffCount = 3'd2;
  localparam logic [2:0] OffLbaLo = 3'd3;
  localparam logic [2:0] OffLbaMid = 3'd4;
  localparam logic [2:0] OffLbaHi = 3'd5;
  localparam logic [2:0] OffDrive = 3'd6;
  localparam logic [2:0] OffCmd   = 3'd7;

  localparam logic [7:0] OpRead28   = 8'h20;
  localparam logic [7:0] OpRead48   = 8'h24;
  localparam logic [7:0] OpWrite28  = 8'h30;
  localparam logic [7:0] OpWrite48  = 8'h34;
  localparam logic [7:0] OpFlush28  = 8'hE7;
  localparam logic [7:0] OpFlush48  = 8'hEA;
  localparam logic [7:0] DriveBase  = 8'hA0;
  localparam logic [7:0] DriveLba   = 8'h40;
  localparam logic [7:0] DriveSlave = 8'h10;

  localparam logic [EndW-1:0] Lba28Limit = EndW'(64'd1 << 28);
  localparam logic [CntW-1:0] MaxCnt28   = 17'd256;
  localparam logic [CntW-1:0] MaxCnt48   = 17'd65536;

  typedef enum logic [1:0] {
    KindErr,
    KindFlush,
    KindLba28,
    KindLba48
  } atci_kind_e;

  typedef struct packed {
    logic [CmdW-1:0] command;
    logic [LbaW-1:0] start_sector;
    logic [CntW-1:0] sector_count;
  } atci_in_t;

  typedef struct packed {
    logic [2:0] reg_offset;
    logic [7:0] reg_value;
    logic       status;
    logic       last;
  } atci_out_t;

  typedef struct packed {
    atci_kind_e      kind;
    logic [7:0]      drive;
    logic [7:0]      opcode;
    logic [LbaW-1:0] lba;
    logic [15:0]     cnt;
  } atci_desc_t;

  typedef struct packed {
    logic full;
    logic valid;
  } atci_qstat_t;

  function automatic logic [StepW-1:0] last_step(atci_kind_e kind);
    logic [StepW-1:0] s;
    unique case (kind)
      KindErr:   s = 4'd0;
      KindFlush: s = 4'd1;
      KindLba28: s = 4'd5;
      KindLba48: s = 4'd9;
      default:   s = 4'd0;
    endcase
    return s;
  endfunction

  function automatic atci_out_t beat(atci_desc_t d, logic [StepW-1:0] step);
    atci_out_t o;
    o.status = 1'b0;
    o.last   = (step == last_step(d.kind));
    o.reg_offset = OffCmd;
    o.reg_value  = d.opcode;
    unique case (d.kind)
      KindErr: begin
        o.reg_offset = OffNone;
        o.reg_value  = 8'h00;
        o.status     = 1'b1;
        o.last       = 1'b1;
      end
      KindFlush: begin
        if (step == 4'd0) begin
          o.reg_offset = OffDrive;
          o.reg_value  = d.drive;
        end
      end
      KindLba28: begin
        unique case (step)
          4'd0: begin o.reg_offset = OffDrive;  o.reg_value = d.drive;       end
          4'd1: begin o.reg_offset = OffCount;  o.reg_value = d.cnt[7:0];    end
          4'd2: begin o.reg_offset = OffLbaLo;  o.reg_value = d.lba[7:0];    end
          4'd3: begin o.reg_offset = OffLbaMid; o.reg_value = d.lba[15:8];   end
          4'd4: begin o.reg_offset = OffLbaHi;  o.reg_value = d.lba[23:16];  end
          default: ;
        endcase
      end
      KindLba48: begin
        unique case (step)
          4'd0: begin o.reg_offset = OffDrive;  o.reg_value = d.drive;       end
          4'd1: begin o.reg_offset = OffCount;  o.reg_value = d.cnt[15:8];   end
          4'd2: begin o.reg_offset = OffLbaLo;  o.reg_value = d.lba[31:24];  end
          4'd3: begin o.reg_offset = OffLbaMid; o.reg_value = d.lba[39:32];  end
          4'd4: begin o.reg_offset = OffLbaHi;  o.reg_value = d.lba[47:40];  end
          4'd5: begin o.reg_offset = OffCount;  o.reg_value = d.cnt[7:0];    end
          4'd6: begin o.reg_offset = OffLbaLo;  o.reg_value = d.lba[7:0];    end
          4'd7: begin o.reg_offset = OffLbaMid; o.reg_value = d.lba[15:8];   end
          4'd8: begin o.reg_offset = OffLbaHi;  o.reg_value = d.lba[23:16];  end
          default: ;
        endcase
      end
      default: ;
    endcase
    return o;
  endfunction

endpackage

FILE: sv/atci_front.sv
// Front end: drive configuration, request intake, range checks and classification.
module atci_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [atci_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [atci_pkg::CfgW-1:0]       cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  atci_pkg::atci_in_t              in_data_i,
  input  atci_pkg::atci_qstat_t           q_stat_i,
  output logic                            push_o,
  output atci_pkg::atci_desc_t            desc_o
);

  logic                            cap48_q;
  logic                            slave_q;
  logic [atci_pkg::Cap28W-1:0]     cap28_q;
  logic [atci_pkg::Cap48W-1:0]     cap48sz_q;

  logic                            stg_valid_q, stg_valid_d;
  logic [atci_pkg::CmdW-1:0]       cmd_q;
  logic [atci_pkg::LbaW-1:0]       lba_q;
  logic [atci_pkg::CntW-1:0]       cnt_q;
  logic [atci_pkg::EndW-1:0]       end_q;

  logic take, stg_ready, is_write, wide, cnt_bad, big28;
  logic [7:0] slave_bit;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap48_q   <= 1'b0;
      slave_q   <= 1'b0;
      cap28_q   <= '0;
      cap48sz_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        atci_pkg::CfgLba48Capable: cap48_q   <= cfg_data_i[0];
        atci_pkg::CfgIsSlave:      slave_q   <= cfg_data_i[0];
        atci_pkg::CfgLba28Cap:     cap28_q   <= cfg_data_i[atci_pkg::Cap28W-1:0];
        atci_pkg::CfgLba48Cap:     cap48sz_q <= cfg_data_i[atci_pkg::Cap48W-1:0];
        default: ;
      endcase
    end
  end

  assign push_o      = stg_valid_q && !q_stat_i.full;
  assign stg_ready   = !stg_valid_q || !q_stat_i.full;
  assign in_stall_o  = !stg_ready;
  assign take        = in_valid_i && stg_ready;
  assign stg_valid_d = take || (stg_valid_q && q_stat_i.full);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_valid_q <= 1'b0;
    end else begin
      stg_valid_q <= stg_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      cmd_q <= in_data_i.command;
      lba_q <= in_data_i.start_sector;
      cnt_q <= in_data_i.sector_count;
      end_q <= atci_pkg::EndW'(in_data_i.start_sector)
             + atci_pkg::EndW'(in_data_i.sector_count);
    end
  end

  assign is_write  = (cmd_q == atci_pkg::CmdWrite);
  assign slave_bit = slave_q ? atci_pkg::DriveSlave : 8'h00;
  assign cnt_bad   = (cnt_q == '0) || (cnt_q > atci_pkg::MaxCnt48);
  assign big28     = cnt_q > atci_pkg::MaxCnt28;
  assign wide      = cap48_q && ((lba_q[atci_pkg::LbaW-1:28] != '0)
                   || (end_q > atci_pkg::Lba28Limit) || big28);

  always_comb begin
    desc_o.kind   = atci_pkg::KindErr;
    desc_o.drive  = atci_pkg::DriveBase | atci_pkg::DriveLba | slave_bit;
    desc_o.opcode = is_write ? atci_pkg::OpWrite28 : atci_pkg::OpRead28;
    desc_o.lba    = lba_q;
    desc_o.cnt    = cnt_q[15:0];
    priority if (cmd_q == atci_pkg::CmdBad) begin
      desc_o.kind = atci_pkg::KindErr;
    end else if (cmd_q == atci_pkg::CmdFlush) begin
      desc_o.kind   = atci_pkg::KindFlush;
      desc_o.drive  = atci_pkg::DriveBase | slave_bit
                    | (cap48_q ? atci_pkg::DriveLba : 8'h00);
      desc_o.opcode = cap48_q ? atci_pkg::OpFlush48 : atci_pkg::OpFlush28;
    end else if (cnt_bad) begin
      desc_o.kind = atci_pkg::KindErr;
    end else if (wide) begin
      desc_o.kind   = (end_q > cap48sz_q) ? atci_pkg::KindErr : atci_pkg::KindLba48;
      desc_o.opcode = is_write ? atci_pkg::OpWrite48 : atci_pkg::OpRead48;
    end else begin
      desc_o.kind  = (big28 || end_q > atci_pkg::Lba28Limit
                   || end_q > atci_pkg::EndW'(cap28_q))
                   ? atci_pkg::KindErr : atci_pkg::KindLba28;
      desc_o.drive = atci_pkg::DriveBase | atci_pkg::DriveLba | slave_bit
                   | {4'h0, lba_q[27:24]};
    end
  end

endmodule

FILE: sv/atci_queue.sv
// Short descriptor queue between the front end and the register sequencer.
module atci_queue (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  atci_pkg::atci_desc_t   desc_i,
  input  logic                   pop_i,
  output atci_pkg::atci_qstat_t  stat_o,
  output atci_pkg::atci_desc_t   head_o
);

  atci_pkg::atci_desc_t            mem_q [atci_pkg::QDepth];
  logic [atci_pkg::QPtrW-1:0]      wr_q, wr_d, rd_q, rd_d;
  logic [atci_pkg::QCntW-1:0]      cnt_q, cnt_d;
  logic                            do_push, do_pop;

  assign stat_o.full  = (cnt_q == atci_pkg::QCntW'(atci_pkg::QDepth));
  assign stat_o.valid = (cnt_q != '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && stat_o.valid;
  assign head_o       = mem_q[rd_q];

  always_comb begin
    wr_d  = do_push ? wr_q + 1'b1 : wr_q;
    rd_d  = do_pop  ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= desc_i;
    end
  end

endmodule

FILE: sv/atci_back.sv
// Register sequencer: walks each descriptor and emits one taskfile write per beat, or one status beat for an error.
module atci_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  atci_pkg::atci_qstat_t  q_stat_i,
  input  atci_pkg::atci_desc_t   head_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output atci_pkg::atci_out_t    out_data_o
);

  logic                          out_valid_q, out_valid_d;
  atci_pkg::atci_out_t           out_q;
  logic [atci_pkg::StepW-1:0]    step_q, step_d;
  logic                          adv, emit, fin;

  assign adv  = !out_valid_q || !out_stall_i;
  assign emit = adv && q_stat_i.valid;
  assign fin  = (step_q == atci_pkg::last_step(head_i.kind));
  assign pop_o = emit && fin;

  always_comb begin
    out_valid_d = adv ? q_stat_i.valid : out_valid_q;
    step_d      = step_q;
    if (emit) begin
      step_d = fin ? '0 : step_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      step_q      <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      step_q      <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q <= atci_pkg::beat(head_i, step_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

FILE: sv/ata_taskfile_command_issuer_core.sv
// Path: an accepted request passes the front-end staging register, the queue and the beat register.
// Throughput: one beat per cycle while out_stall_i is low; a request issues 1 (error), 2 (flush),
// 6 (28-bit) or 10 (48-bit) beats from the single result register of the sequencer.
// Requests enter back to back while the staging register or the two-entry queue has room.
// Reset: asynchronous, active low; clears control state and all drive configuration to zero.
module ata_taskfile_command_issuer_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [atci_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [atci_pkg::CfgW-1:0]     cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  atci_pkg::atci_in_t            in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output atci_pkg::atci_out_t           out_data_o
);

  atci_pkg::atci_qstat_t q_stat;
  atci_pkg::atci_desc_t  desc, head;
  logic                  push, pop;

  atci_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .q_stat_i    (q_stat),
    .push_o      (push),
    .desc_o      (desc)
  );

  atci_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .desc_i (desc),
    .pop_i  (pop),
    .stat_o (q_stat),
    .head_o (head)
  );

  atci_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_stat_i    (q_stat),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

FILE: sv/atci_checker.sv
// Port-level checker for the ATA taskfile command issuer, bound to the top level.
`include "ata_taskfile_command_issuer_core_assert.svh"

module atci_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          cfg_valid_i,
  input logic                          cfg_ready_o,
  input logic [atci_pkg::CfgIdxW-1:0]  cfg_index_i,
  input logic [atci_pkg::CfgW-1:0]     cfg_data_i,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input atci_pkg::atci_in_t            in_data_i,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input atci_pkg::atci_out_t           out_data_o
);

  // stalled beat holds
  `ATCI_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_data_o))

  // error beat stands alone and writes nothing
  `ATCI_ASSERT_NOW(a_err_beat, out_valid_o && out_data_o.status,
    out_data_o.last && out_data_o.reg_offset == atci_pkg::OffNone && out_data_o.reg_value == 8'h00)

  // ok requests end on the command register
  `ATCI_ASSERT_NOW(a_last_cmd, out_valid_o && !out_data_o.status && out_data_o.last,
    out_data_o.reg_offset == atci_pkg::OffCmd)

  // the command register is only written on the final beat
  `ATCI_ASSERT_NOW(a_cmd_last, out_valid_o && out_data_o.reg_offset == atci_pkg::OffCmd,
    out_data_o.last && !out_data_o.status)

endmodule

bind ata_taskfile_command_issuer_core atci_checker u_atci_checker (.*);
